[rtl/core/usd_pkg.sv]
`default_nettype none

package usd_pkg;

    localparam int USD_QUEUE_DEPTH = 4;

    // byte classification masks and patterns
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    localparam logic KIND_DECODED = 1'b0;
    localparam logic KIND_RAW     = 1'b1;

    localparam logic [2:0] LEN_RAW = 3'd1;

    // work for one input byte: raw bytes to flush, then an optional final result
    typedef struct packed {
        logic [1:0]      flush_cnt;
        logic [2:0][7:0] flush_bytes;
        logic            has_final;
        logic [20:0]     final_value;
        logic            final_kind;
        logic [2:0]      final_len;
    } usd_desc_t;

endpackage

`default_nettype wire

[rtl/core/usd_front.sv]
`default_nettype none

module usd_front
    import usd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // stream_end
    output usd_desc_t       desc,
    output logic            desc_valid,
    input  wire logic       desc_ready
);

    logic [2:0][7:0] pend_bytes_reg, pend_bytes_next;
    logic [1:0]      pend_cnt_reg, pend_cnt_next;
    logic [2:0]      exp_len_reg, exp_len_next;
    logic [20:0]     partial_reg, partial_next;

    logic            accept;
    logic            do_fresh;
    logic [7:0]      b;
    logic [20:0]     partial_ext;
    logic [2:0]      lead_len;
    logic [20:0]     lead_payload;

    assign s_tready = desc_ready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    assign partial_ext = {partial_reg[14:0], b[5:0]};

    always_comb begin
        lead_len     = 3'd0;
        lead_payload = '0;
        if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            lead_len     = 3'd4;
            lead_payload = {18'd0, b[2:0]};
        end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            lead_len     = 3'd3;
            lead_payload = {17'd0, b[3:0]};
        end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            lead_len     = 3'd2;
            lead_payload = {16'd0, b[4:0]};
        end
    end

    always_comb begin
        pend_bytes_next  = pend_bytes_reg;
        pend_cnt_next    = pend_cnt_reg;
        exp_len_next     = exp_len_reg;
        partial_next     = partial_reg;
        desc             = '0;
        desc.flush_bytes = pend_bytes_reg;
        do_fresh         = 1'b0;

        if (accept) begin
            if (pend_cnt_reg != 2'd0) begin
                if ((b & CONT_MASK) == CONT_PAT) begin
                    if (({1'b0, pend_cnt_reg} + 3'd1) >= exp_len_reg) begin
                        // sequence complete
                        desc.has_final   = 1'b1;
                        desc.final_value = partial_ext;
                        desc.final_kind  = KIND_DECODED;
                        desc.final_len   = exp_len_reg;
                        pend_cnt_next    = 2'd0;
                        exp_len_next     = 3'd0;
                        partial_next     = '0;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            if (pend_cnt_reg == 2'(i)) begin
                                pend_bytes_next[i]  = b;
                                desc.flush_bytes[i] = b;
                            end
                        end
                        if (s_tlast) begin
                            // cut off at stream end: flush everything raw
                            desc.flush_cnt = pend_cnt_reg + 2'd1;
                            pend_cnt_next  = 2'd0;
                            exp_len_next   = 3'd0;
                            partial_next   = '0;
                        end else begin
                            pend_cnt_next = pend_cnt_reg + 2'd1;
                            partial_next  = partial_ext;
                        end
                    end
                end else begin
                    // broken sequence: flush, then treat this byte afresh
                    desc.flush_cnt = pend_cnt_reg;
                    pend_cnt_next  = 2'd0;
                    exp_len_next   = 3'd0;
                    partial_next   = '0;
                    do_fresh       = 1'b1;
                end
            end else begin
                do_fresh = 1'b1;
            end

            if (do_fresh) begin
                if (lead_len != 3'd0 && !s_tlast) begin
                    pend_bytes_next[0] = b;
                    pend_cnt_next      = 2'd1;
                    exp_len_next       = lead_len;
                    partial_next       = lead_payload;
                end else begin
                    desc.has_final   = 1'b1;
                    desc.final_value = {13'd0, b};
                    desc.final_kind  = KIND_RAW;
                    desc.final_len   = LEN_RAW;
                    pend_cnt_next    = 2'd0;
                    exp_len_next     = 3'd0;
                    partial_next     = '0;
                end
            end
        end
    end

    assign desc_valid = accept && (desc.flush_cnt != 2'd0 || desc.has_final);

    always_ff @(posedge aclk) begin
        pend_bytes_reg <= pend_bytes_next;
        if (!aresetn) begin
            pend_cnt_reg <= 2'd0;
            exp_len_reg  <= 3'd0;
            partial_reg  <= '0;
        end else begin
            pend_cnt_reg <= pend_cnt_next;
            exp_len_reg  <= exp_len_next;
            partial_reg  <= partial_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/usd_queue.sv]
`default_nettype none

module usd_queue
    import usd_pkg::*;
#(
    parameter int DEPTH = USD_QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire usd_desc_t wr_desc,
    input  wire logic      wr_valid,
    output logic           wr_ready,
    output usd_desc_t      rd_desc,
    output logic           rd_valid,
    input  wire logic      rd_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    usd_desc_t              entries_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_desc  = entries_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= wr_desc;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/usd_back.sv]
`default_nettype none

module usd_back
    import usd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire usd_desc_t desc,
    input  wire logic      desc_valid,
    output logic           desc_pop,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output logic [23:0]    m_tdata,   // [20:0] value, [23:21] seq_len
    output logic           m_tuser,   // kind
    output logic           m_tlast    // last_of_run
);

    logic [1:0]  idx_reg, idx_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    logic        load;
    logic        last_res;
    logic [2:0]  total;
    logic [20:0] res_value;
    logic        res_kind;
    logic [2:0]  res_len;

    assign total    = {1'b0, desc.flush_cnt} + {2'b0, desc.has_final};
    assign last_res = ({1'b0, idx_reg} + 3'd1) == total;
    assign load     = desc_valid && (!m_tvalid_reg || m_tready);
    assign desc_pop = load && last_res;

    always_comb begin
        res_value = desc.final_value;
        res_kind  = desc.final_kind;
        res_len   = desc.final_len;
        if ({1'b0, idx_reg} < {1'b0, desc.flush_cnt}) begin
            res_kind = KIND_RAW;
            res_len  = LEN_RAW;
            case (idx_reg)
                2'd0:    res_value = {13'd0, desc.flush_bytes[0]};
                2'd1:    res_value = {13'd0, desc.flush_bytes[1]};
                2'd2:    res_value = {13'd0, desc.flush_bytes[2]};
                default: res_value = desc.final_value;
            endcase
        end
    end

    always_comb begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {res_len, res_value};
            m_tuser_next  = res_kind;
            m_tlast_next  = last_res;
            // advance within the entry, or wrap when it is popped
            idx_next      = last_res ? 2'd0 : idx_reg + 2'd1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        if (!aresetn) begin
            idx_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

[rtl/core/utf8_stream_decoder.sv]
// Lenient UTF-8 stream decoder.
// Input channel s_*: one byte per word in s_tdata, s_tlast marks the final byte
// of the stream; an unfinished sequence at that byte is flushed as raw bytes.
// Output channel m_*: one result per word. m_tdata carries the code point (or
// raw byte) and the number of input bytes it used; m_tuser is 0 for a decoded
// sequence and 1 for a raw byte; m_tlast marks the last result of an input byte.
// A byte that only extends an open sequence produces no word.
// A result is registered in the descriptor queue, written by the front stage,
// and again in the output register, loaded by the back stage.
// Throughput: one input byte per cycle while each byte yields at most one
// result and m_tready is high; the output register issues one result per
// cycle while m_tready is high. A broken sequence yields up to four results
// for one byte; the descriptor queue (QUEUE_DEPTH entries) absorbs these
// bursts and s_tready drops only when it is full.
// Reset (aresetn low, synchronous) empties the queue, drops any open sequence
// and clears m_tvalid. When the receiver holds m_tready low the output word
// holds, the queue fills, and then s_tready falls.
`default_nettype none

module utf8_stream_decoder
    import usd_pkg::*;
#(
    parameter int QUEUE_DEPTH = USD_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // stream_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] value, [23:21] seq_len
    output logic             m_tuser,   // kind
    output logic             m_tlast    // last_of_run
);

    usd_desc_t front_desc;
    logic      front_valid;
    logic      queue_ready;
    usd_desc_t back_desc;
    logic      back_valid;
    logic      back_pop;

    usd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .desc       (front_desc),
        .desc_valid (front_valid),
        .desc_ready (queue_ready)
    );

    usd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_desc  (front_desc),
        .wr_valid (front_valid),
        .wr_ready (queue_ready),
        .rd_desc  (back_desc),
        .rd_valid (back_valid),
        .rd_pop   (back_pop)
    );

    usd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc       (back_desc),
        .desc_valid (back_valid),
        .desc_pop   (back_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
